// ===== hw/rtl/dtwtb_pkg.sv =====
// Shared types, codes and defaults of the DTW traceback path block.
package dtwtb_pkg;

   // Default matrix bounds handed to the top level parameters.
   localparam int DEFAULT_MAX_ROWS = 64;
   localparam int DEFAULT_MAX_COLS = 64;

   // Size registers come out of reset at this value, saturated to the bound.
   localparam int CFG_SIZE_RESET = 64;
   localparam int CFG_W          = 7;

   // Request operation codes.
   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_TRACE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_LEFT  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_ROWS = 2'd0,
      CSR_COLS = 2'd1
   } csr_index_type;

   // Step code layout: bit 0 moves one column left, bit 1 moves one row up.
   localparam logic [1:0] DIR_STOP     = 2'd0;
   localparam int         DIR_LEFT_BIT = 0;
   localparam int         DIR_UP_BIT   = 1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic access;
      logic walk_read;
      logic walk_step;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_trace;
      logic walk_stop;
      logic walk_error;
   } stat_type;

endpackage

// ===== hw/rtl/dtwtb_ctrl.sv =====
// Controller state machine of the DTW traceback path block.
module dtwtb_ctrl
   import dtwtb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ACCESS = 5'b00010,
      ST_WREAD  = 5'b00100,
      ST_WSTEP  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // A transaction is taken only while the controller is idle.
   assign accept = start && (state_ff == ST_IDLE);

   // Next state: single accesses go through one memory cycle, a traceback
   // alternates between reading a cell and stepping to its neighbor.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = stat.is_trace ? ST_WREAD : ST_ACCESS;
            end
         end
         ST_ACCESS: state_in = ST_FINISH;
         ST_WREAD:  state_in = ST_WSTEP;
         ST_WSTEP: begin
            if (stat.walk_stop || stat.walk_error) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_WREAD;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = (state_ff == ST_FINISH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Commands decoded from the state.
   always_comb begin
      cmd.latch     = accept;
      cmd.access    = (state_ff == ST_ACCESS);
      cmd.walk_read = (state_ff == ST_WREAD);
      cmd.walk_step = (state_ff == ST_WSTEP);
      cmd.finish    = (state_ff == ST_FINISH);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // A response strobe lasts exactly one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for more than one cycle");

   // Every response follows the finishing state.
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_FINISH))
      else $error("response strobe without a finishing cycle");

   // A single-access transaction answers through the access and finishing states.
   a_access_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && !stat.is_trace) |-> ##3 rsp_valid_ff)
      else $error("single-access transaction did not answer in three cycles");

   // A step that neither stops nor fails goes on to read the next cell.
   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WSTEP && !stat.walk_stop && !stat.walk_error)
      |=> (state_ff == ST_WREAD))
      else $error("traceback walk did not continue");
`endif

endmodule

// ===== hw/rtl/dtwtb_datapath.sv =====
// Datapath of the DTW traceback path block: memories, walk registers, results.
module dtwtb_datapath
   import dtwtb_pkg::*;
#(
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = DEFAULT_MAX_COLS
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic [1:0]       req_mode,
   input  logic [5:0]       req_row,
   input  logic [5:0]       req_col,
   input  logic [1:0]       req_direction,
   input  logic [6:0]       req_path_index,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_path_length,
   output logic [6:0]       rsp_path_row,
   output logic [6:0]       rsp_path_col,
   output logic             rsp_on_path,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int RW     = $clog2(MAX_ROWS);
   localparam int CW     = $clog2(MAX_COLS);
   localparam int CELLS  = MAX_ROWS * MAX_COLS;
   localparam int CAW    = $clog2(CELLS);
   localparam int PDEPTH = MAX_ROWS + MAX_COLS - 1;
   localparam int PAW    = $clog2(PDEPTH);
   localparam int LW     = $clog2(PDEPTH + 1);
   localparam int SRW    = $clog2(MAX_ROWS + 1);
   localparam int SCW    = $clog2(MAX_COLS + 1);
   localparam int ROWS_RESET = (CFG_SIZE_RESET > MAX_ROWS) ? MAX_ROWS : CFG_SIZE_RESET;
   localparam int COLS_RESET = (CFG_SIZE_RESET > MAX_COLS) ? MAX_COLS : CFG_SIZE_RESET;

   // Configuration registers.
   logic [SRW-1:0] rows_ff, rows_in;
   logic [SCW-1:0] cols_ff, cols_in;

   // Latched request fields.
   mode_type   mode_ff;
   logic [5:0] row_ff;
   logic [5:0] col_ff;
   logic [1:0] dir_ff;
   logic [6:0] idx_ff;

   // Walk registers.
   logic [RW-1:0] walk_i_ff, walk_i_in;
   logic [CW-1:0] walk_j_ff, walk_j_in;
   logic [LW-1:0] walk_n_ff, walk_n_in;
   logic          new_row_ff, new_row_in;

   // Outcome of the last traceback.
   logic [LW-1:0] traced_ff, traced_in;
   logic [RW-1:0] first_row_ff;
   logic [RW-1:0] last_row_ff;
   status_type    walk_status_ff;

   // Memories and their registered read data.
   logic [1:0]    dir_mem [CELLS];
   logic [1:0]    dir_rd_ff;
   logic [RW-1:0] path_r_mem [PDEPTH];
   logic [CW-1:0] path_c_mem [PDEPTH];
   logic [RW-1:0] path_r_rd_ff;
   logic [CW-1:0] path_c_rd_ff;
   logic [CW-1:0] minc_mem [MAX_ROWS];
   logic [CW-1:0] maxc_mem [MAX_ROWS];
   logic [CW-1:0] minc_rd_ff;
   logic [CW-1:0] maxc_rd_ff;

   // Result registers.
   status_type rsp_status_ff;
   logic [6:0] rsp_path_length_ff;
   logic [6:0] rsp_path_row_ff;
   logic [6:0] rsp_path_col_ff;
   logic       rsp_on_path_ff;

   logic           csr_we;
   logic           cell_ok;
   logic [CAW-1:0] req_addr;
   logic [CAW-1:0] walk_addr;
   logic           in_range;
   logic [LW-1:0]  rd_pos;
   logic [PAW-1:0] path_raddr;
   logic [PAW-1:0] path_waddr;
   logic [1:0]     step_dir;
   logic           step_stop;
   logic           step_error;
   logic [RW:0]    prow_full;
   logic [CW:0]    pcol_full;
   logic           on_path_hit;

   // Configuration writes; sizes outside the matrix bounds are saturated.
   assign csr_we = csr_valid && csr_ready;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS: begin
               if (csr_wdata == '0) begin
                  rows_in = SRW'(1);
               end else if (int'(csr_wdata) > MAX_ROWS) begin
                  rows_in = SRW'(MAX_ROWS);
               end else begin
                  rows_in = SRW'(csr_wdata);
               end
            end
            CSR_COLS: begin
               if (csr_wdata == '0) begin
                  cols_in = SCW'(1);
               end else if (int'(csr_wdata) > MAX_COLS) begin
                  cols_in = SCW'(MAX_COLS);
               end else begin
                  cols_in = SCW'(csr_wdata);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Request fields are held for the length of the transaction.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= mode_type'(req_mode);
         row_ff  <= req_row;
         col_ff  <= req_col;
         dir_ff  <= req_direction;
         idx_ff  <= req_path_index;
      end
   end

   // Cell addresses for the latched request and for the walk position.
   assign cell_ok   = (int'(row_ff) < MAX_ROWS) && (int'(col_ff) < MAX_COLS);
   assign req_addr  = CAW'(CAW'(row_ff) * CAW'(MAX_COLS) + CAW'(col_ff));
   assign walk_addr = CAW'(CAW'(walk_i_ff) * CAW'(MAX_COLS) + CAW'(walk_j_ff));

   // The walk stores cells from the end backward, so forward entry k sits
   // at position length - 1 - k.
   assign in_range   = (int'(idx_ff) < int'(traced_ff));
   assign rd_pos     = traced_ff - LW'(1) - LW'(idx_ff);
   assign path_raddr = PAW'(rd_pos);
   assign path_waddr = PAW'(walk_n_ff);

   // Step decode on the code just read from the direction memory.
   assign step_dir   = dir_rd_ff;
   assign step_stop  = (step_dir == DIR_STOP);
   assign step_error = (step_dir[DIR_LEFT_BIT] && (walk_j_ff == '0)) ||
                       (step_dir[DIR_UP_BIT] && (walk_i_ff == '0));

   always_comb begin
      stat.is_trace   = (mode_type'(req_mode) == MODE_TRACE);
      stat.walk_stop  = step_stop;
      stat.walk_error = step_error;
   end

   // Walk position, path length and traced length.
   always_comb begin
      walk_i_in  = walk_i_ff;
      walk_j_in  = walk_j_ff;
      walk_n_in  = walk_n_ff;
      new_row_in = new_row_ff;
      traced_in  = traced_ff;
      if (cmd.latch && stat.is_trace) begin
         walk_i_in  = RW'(rows_ff - SRW'(1));
         walk_j_in  = CW'(cols_ff - SCW'(1));
         walk_n_in  = '0;
         new_row_in = 1'b1;
      end else if (cmd.walk_step) begin
         if (step_stop) begin
            traced_in = walk_n_ff + LW'(1);
         end else if (step_error) begin
            traced_in = '0;
         end else begin
            if (step_dir[DIR_LEFT_BIT]) begin
               walk_j_in = walk_j_ff - CW'(1);
            end
            if (step_dir[DIR_UP_BIT]) begin
               walk_i_in = walk_i_ff - RW'(1);
            end
            walk_n_in  = walk_n_ff + LW'(1);
            new_row_in = step_dir[DIR_UP_BIT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= SRW'(ROWS_RESET);
         cols_ff   <= SCW'(COLS_RESET);
         traced_ff <= '0;
      end else begin
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         traced_ff <= traced_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_i_ff  <= walk_i_in;
      walk_j_ff  <= walk_j_in;
      walk_n_ff  <= walk_n_in;
      new_row_ff <= new_row_in;
      if (cmd.latch && stat.is_trace) begin
         last_row_ff <= RW'(rows_ff - SRW'(1));
      end
      if (cmd.walk_step) begin
         if (step_stop) begin
            first_row_ff   <= walk_i_ff;
            walk_status_ff <= STATUS_OK;
         end else if (step_error) begin
            walk_status_ff <= STATUS_LEFT;
         end
      end
   end

   // Direction memory: written by single accesses, read by the walk.
   always_ff @(posedge clock) begin
      if (cmd.access && (mode_ff == MODE_WRITE) && cell_ok) begin
         dir_mem[req_addr] <= dir_ff;
      end
      if (cmd.walk_read) begin
         dir_rd_ff <= dir_mem[walk_addr];
      end
   end

   // Path memory: the walk writes each visited cell, reads pick one entry.
   always_ff @(posedge clock) begin
      if (cmd.walk_read) begin
         path_r_mem[path_waddr] <= walk_i_ff;
         path_c_mem[path_waddr] <= walk_j_ff;
      end
      if (cmd.access) begin
         path_r_rd_ff <= path_r_mem[path_raddr];
         path_c_rd_ff <= path_c_mem[path_raddr];
      end
   end

   // Column bounds of the path in each row. The path is a monotone
   // staircase, so a cell is on it exactly when its row lies between the
   // stop row and the last row and its column lies within that row's bounds.
   always_ff @(posedge clock) begin
      if (cmd.walk_read) begin
         minc_mem[walk_i_ff] <= walk_j_ff;
         if (new_row_ff) begin
            maxc_mem[walk_i_ff] <= walk_j_ff;
         end
      end
      if (cmd.access) begin
         minc_rd_ff <= minc_mem[RW'(row_ff)];
         maxc_rd_ff <= maxc_mem[RW'(row_ff)];
      end
   end

   // Result fields.
   assign prow_full   = {1'b0, path_r_rd_ff} + {{RW{1'b0}}, 1'b1};
   assign pcol_full   = {1'b0, path_c_rd_ff} + {{CW{1'b0}}, 1'b1};
   assign on_path_hit = cell_ok && (traced_ff != '0) &&
                        (row_ff >= first_row_ff) && (row_ff <= last_row_ff) &&
                        (col_ff >= minc_rd_ff) && (col_ff <= maxc_rd_ff);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_path_length_ff <= 7'(traced_ff);
         rsp_path_row_ff    <= '0;
         rsp_path_col_ff    <= '0;
         rsp_on_path_ff     <= 1'b0;
         case (mode_ff)
            MODE_TRACE: rsp_status_ff <= walk_status_ff;
            MODE_READ: begin
               if (in_range) begin
                  rsp_status_ff   <= STATUS_OK;
                  rsp_path_row_ff <= 7'(prow_full);
                  rsp_path_col_ff <= 7'(pcol_full);
               end else begin
                  rsp_status_ff <= STATUS_RANGE;
               end
            end
            MODE_QUERY: begin
               rsp_status_ff  <= STATUS_OK;
               rsp_on_path_ff <= on_path_hit;
            end
            default: rsp_status_ff <= STATUS_OK;
         endcase
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_path_length = rsp_path_length_ff;
   assign rsp_path_row    = rsp_path_row_ff;
   assign rsp_path_col    = rsp_path_col_ff;
   assign rsp_on_path     = rsp_on_path_ff;

endmodule

// ===== hw/rtl/dtw_traceback_path_core.sv =====
// Top level of the DTW traceback path block: controller plus datapath.
// Direction writes, path reads and cell queries strobe their result after the access
// and finishing states, and the next transaction is taken in the strobe cycle.
// A traceback runs a read-then-step loop on the direction memory over a path of L
// cells (L up to rows + cols - 1).
// Synchronous active-high reset clears the controller, the traced length and the
// size registers (64, saturated to the bounds); no memory clearing pass is needed.
module dtw_traceback_path_core
   import dtwtb_pkg::*;
#(
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = DEFAULT_MAX_COLS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_mode,
   input  logic [5:0]       req_row,
   input  logic [5:0]       req_col,
   input  logic [1:0]       req_direction,
   input  logic [6:0]       req_path_index,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_path_length,
   output logic [6:0]       rsp_path_row,
   output logic [6:0]       rsp_path_col,
   output logic             rsp_on_path,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // Size registers take writes only between transactions.
   assign csr_ready = !busy;

   dtwtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   dtwtb_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_direction   (req_direction),
      .req_path_index  (req_path_index),
      .rsp_status      (rsp_status),
      .rsp_path_length (rsp_path_length),
      .rsp_path_row    (rsp_path_row),
      .rsp_path_col    (rsp_path_col),
      .rsp_on_path     (rsp_on_path),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule

// ===== bench/dtw_traceback_path_core_tb.sv =====
// Self-checking testbench for the DTW traceback path core with a predicting scoreboard.
`timescale 1ns / 1ps

module dtw_traceback_path_core_tb;
   import dtwtb_pkg::*;

   localparam int ROWS_MAX    = DEFAULT_MAX_ROWS;
   localparam int COLS_MAX    = DEFAULT_MAX_COLS;
   localparam int PATH_DEPTH  = ROWS_MAX + COLS_MAX - 1;
   localparam int CYCLE_LIMIT = 1000000;

   // Register indexes that map to no register; writes to them must be ignored.
   localparam logic [1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [1:0] CSR_UNMAPPED_B = 2'd3;

   // One response as the block should present it.
   typedef struct packed {
      status_type status;
      logic [6:0] length;
      logic [6:0] row;
      logic [6:0] col;
      logic       on_path;
   } path_rsp_type;

   // Mirror of the direction matrix, the traced path and its mask.
   class path_board;
      int           rows;
      int           cols;
      int           traced_len;
      int           failures;
      logic [1:0]   dir_cells [ROWS_MAX][COLS_MAX];
      bit [COLS_MAX-1:0] written [ROWS_MAX];
      bit [COLS_MAX-1:0] on_mask [ROWS_MAX];
      int           path_r [PATH_DEPTH];
      int           path_c [PATH_DEPTH];
      path_rsp_type awaited [$];

      function new();
         rows = clamp_size(CFG_SIZE_RESET, ROWS_MAX);
         cols = clamp_size(CFG_SIZE_RESET, COLS_MAX);
         traced_len = 0;
         failures = 0;
         for (int r = 0; r < ROWS_MAX; r++) begin
            written[r] = '0;
            on_mask[r] = '0;
         end
      endfunction

      // Zero is taken as one; anything above the bound saturates.
      function int clamp_size(int v, int maxv);
         if (v == 0) return 1;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function void write_csr(logic [1:0] index, logic [CFG_W-1:0] value);
         if (index == CSR_ROWS) rows = clamp_size(int'(value), ROWS_MAX);
         else if (index == CSR_COLS) cols = clamp_size(int'(value), COLS_MAX);
      endfunction

      // Walk back from the bottom-right cell; store the path in forward order.
      function status_type trace_path();
         int i, j, n;
         int wr [PATH_DEPTH];
         int wc [PATH_DEPTH];
         logic [1:0] d;
         for (int r = 0; r < ROWS_MAX; r++) on_mask[r] = '0;
         i = rows - 1;
         j = cols - 1;
         n = 0;
         while (n < PATH_DEPTH) begin
            wr[n] = i;
            wc[n] = j;
            n++;
            d = dir_cells[i][j];
            if (d == DIR_STOP) break;
            if ((d[DIR_LEFT_BIT] && j == 0) || (d[DIR_UP_BIT] && i == 0)) begin
               traced_len = 0;
               return STATUS_LEFT;
            end
            if (d[DIR_LEFT_BIT]) j--;
            if (d[DIR_UP_BIT]) i--;
         end
         for (int k = 0; k < n; k++) begin
            path_r[k] = wr[n - 1 - k];
            path_c[k] = wc[n - 1 - k];
            on_mask[path_r[k]][path_c[k]] = 1'b1;
         end
         traced_len = n;
         return STATUS_OK;
      endfunction

      // Finds the first cell on the coming walk that holds no written code.
      function bit first_unwritten(output int r, output int c);
         int i, j;
         logic [1:0] d;
         i = rows - 1;
         j = cols - 1;
         r = 0;
         c = 0;
         for (int n = 0; n < PATH_DEPTH; n++) begin
            if (!written[i][j]) begin
               r = i;
               c = j;
               return 1'b1;
            end
            d = dir_cells[i][j];
            if (d == DIR_STOP) return 1'b0;
            if ((d[DIR_LEFT_BIT] && j == 0) || (d[DIR_UP_BIT] && i == 0)) return 1'b0;
            if (d[DIR_LEFT_BIT]) j--;
            if (d[DIR_UP_BIT]) i--;
         end
         return 1'b0;
      endfunction

      // Called for each accepted request transaction.
      function void note_request(mode_type m, int r, int c, int d, int idx);
         path_rsp_type e;
         e = '0;
         e.status = STATUS_OK;
         case (m)
            MODE_WRITE: begin
               dir_cells[r][c] = 2'(d);
               written[r][c] = 1'b1;
            end
            MODE_TRACE: e.status = trace_path();
            MODE_READ: begin
               if (idx < traced_len && idx < PATH_DEPTH) begin
                  e.row = 7'(path_r[idx] + 1);
                  e.col = 7'(path_c[idx] + 1);
               end else begin
                  e.status = STATUS_RANGE;
               end
            end
            MODE_QUERY: e.on_path = on_mask[r][c];
         endcase
         e.length = 7'(traced_len);
         awaited.push_back(e);
      endfunction

      function void compare(string name, int want, int got);
         if (want != got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      // Called for each response transaction.
      function void check_response(logic [1:0] st, logic [6:0] len, logic [6:0] prow,
                                   logic [6:0] pcol, logic onp);
         path_rsp_type e;
         if (awaited.size() == 0) begin
            failures++;
            $display("%0t: response with none awaited, expected nothing, actual status %0d",
                     $time, st);
            return;
         end
         e = awaited.pop_front();
         compare("status", int'(e.status), int'(st));
         compare("path_length", int'(e.length), int'(len));
         compare("path_row", int'(e.row), int'(prow));
         compare("path_col", int'(e.col), int'(pcol));
         compare("on_path", int'(e.on_path), int'(onp));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_mode;
   logic [5:0]       req_row;
   logic [5:0]       req_col;
   logic [1:0]       req_direction;
   logic [6:0]       req_path_index;
   logic             rsp_valid;
   logic [1:0]       rsp_status;
   logic [6:0]       rsp_path_length;
   logic [6:0]       rsp_path_row;
   logic [6:0]       rsp_path_col;
   logic             rsp_on_path;
   logic             csr_valid;
   logic             csr_ready;
   logic [1:0]       csr_index;
   logic [CFG_W-1:0] csr_wdata;

   path_board board;
   int        idle_pct = 0;
   int        sent = 0;
   int        cycle_count = 0;

   dtw_traceback_path_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_direction   (req_direction),
      .req_path_index  (req_path_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_path_length (rsp_path_length),
      .rsp_path_row    (rsp_path_row),
      .rsp_path_col    (rsp_path_col),
      .rsp_on_path     (rsp_on_path),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every strobed response is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_response(rsp_status, rsp_path_length, rsp_path_row, rsp_path_col,
                              rsp_on_path);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** dtw_traceback_path_core: FAILED **");
         $finish;
      end
   end

   // Sends one request transaction, after a random idle gap.
   task automatic issue(mode_type m, int r, int c, int d, int idx);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start          <= 1'b1;
      req_mode       <= m;
      req_row        <= 6'(r);
      req_col        <= 6'(c);
      req_direction  <= 2'(d);
      req_path_index <= 7'(idx);
      do @(posedge clock); while (busy);
      board.note_request(m, r, c, d, idx);
      sent++;
   endtask

   // Fills any unwritten cell the walk would reach, then starts the traceback.
   task automatic run_trace();
      int r, c;
      while (board.first_unwritten(r, c)) begin
         issue(MODE_WRITE, r, c, $urandom_range(3), $urandom_range(127));
      end
      issue(MODE_TRACE, $urandom_range(63), $urandom_range(63), $urandom_range(3),
            $urandom_range(127));
   endtask

   // Lowers start and waits until every response has come back.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= CFG_W'(value);
      do @(posedge clock); while (!csr_ready);
      board.write_csr(index, CFG_W'(value));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_sizes(int rows_w, int cols_w);
      drain();
      csr_write(CSR_ROWS, rows_w);
      csr_write(CSR_COLS, cols_w);
      csr_write($urandom_range(1) ? CSR_UNMAPPED_A : CSR_UNMAPPED_B, $urandom_range(127));
   endtask

   // Lays a random path from the bottom-right cell, traces it, then reads it back and queries cells.
   task automatic path_episode();
      int i, j, k, code;
      bit done;
      i = board.rows - 1;
      j = board.cols - 1;
      done = 1'b0;
      while (!done) begin
         if (i == 0 && j == 0) code = DIR_STOP;
         else if ($urandom_range(99) < 4) code = DIR_STOP;
         else begin
            do code = $urandom_range(1, 3);
            while ((code[DIR_LEFT_BIT] && j == 0) || (code[DIR_UP_BIT] && i == 0));
         end
         // Now and then any code at all, which may step off the matrix.
         if ($urandom_range(99) < 5) code = $urandom_range(3);
         issue(MODE_WRITE, i, j, code, $urandom_range(127));
         if (code == DIR_STOP) done = 1'b1;
         else if ((code[DIR_LEFT_BIT] && j == 0) || (code[DIR_UP_BIT] && i == 0)) done = 1'b1;
         else begin
            if (code[DIR_LEFT_BIT]) j--;
            if (code[DIR_UP_BIT]) i--;
         end
      end
      run_trace();
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(3) == 0) k = $urandom_range(127);
         else k = $urandom_range(board.traced_len);
         issue(MODE_READ, $urandom_range(63), $urandom_range(63), $urandom_range(3), k);
      end
      repeat ($urandom_range(1, 4)) begin
         if (board.traced_len > 0 && $urandom_range(1)) begin
            k = $urandom_range(board.traced_len - 1);
            i = board.path_r[k];
            j = board.path_c[k];
         end else begin
            i = $urandom_range(board.rows - 1);
            j = $urandom_range(board.cols - 1);
         end
         issue(MODE_QUERY, i, j, $urandom_range(3), $urandom_range(127));
      end
   endtask

   task automatic noise_item();
      mode_type m;
      m = mode_type'($urandom_range(3));
      if (m == MODE_TRACE) run_trace();
      else issue(m, $urandom_range(63), $urandom_range(63), $urandom_range(3),
                 $urandom_range(127));
   endtask

   task automatic run_phase(int rows_w, int cols_w, int pct, int items);
      int target;
      apply_sizes(rows_w, cols_w);
      idle_pct = pct;
      target = sent + items;
      while (sent < target) begin
         if ($urandom_range(99) < 80) path_episode();
         else noise_item();
      end
   endtask

   // Hand-picked transactions: empty path, single cell, short walk, walks off the edge.
   task automatic directed();
      issue(MODE_QUERY, 0, 0, 0, 0);
      issue(MODE_READ, 63, 63, 3, 0);
      issue(MODE_WRITE, 63, 63, DIR_STOP, 127);
      run_trace();
      issue(MODE_READ, 0, 0, 0, 0);
      issue(MODE_READ, 0, 0, 0, 127);
      issue(MODE_QUERY, 63, 63, 0, 0);
      issue(MODE_QUERY, 63, 0, 0, 0);
      issue(MODE_WRITE, 63, 63, 1, 0);
      issue(MODE_WRITE, 63, 62, 2, 0);
      issue(MODE_WRITE, 62, 62, 3, 0);
      issue(MODE_WRITE, 61, 61, DIR_STOP, 0);
      run_trace();
      issue(MODE_READ, 0, 0, 0, 3);
      issue(MODE_READ, 0, 0, 0, 0);
      issue(MODE_QUERY, 62, 62, 0, 0);
      // A single-cell matrix: every step code but stop leaves it.
      apply_sizes(1, 1);
      for (int d = 1; d <= 3; d++) begin
         issue(MODE_WRITE, 0, 0, d, 0);
         run_trace();
      end
      issue(MODE_QUERY, 0, 0, 0, 0);
      issue(MODE_WRITE, 0, 0, DIR_STOP, 0);
      run_trace();
      issue(MODE_QUERY, 0, 0, 0, 0);
   endtask

   initial begin
      board = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_mode       = MODE_WRITE;
      req_row        = '0;
      req_col        = '0;
      req_direction  = DIR_STOP;
      req_path_index = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_ROWS;
      csr_wdata      = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      directed();
      run_phase(4, 4, 0, 110);
      run_phase($urandom_range(1, 8), $urandom_range(1, 8), 71, 110);
      run_phase(64, 64, 6, 130);
      run_phase(0, 64, 0, 70);
      run_phase(127, 1, 71, 70);
      run_phase($urandom_range(2, 12), $urandom_range(2, 12), 6, 90);
      run_phase(65, 2, 0, 60);

      drain();
      repeat (20) @(posedge clock);
      if (board.failures == 0) begin
         $display("** dtw_traceback_path_core: PASSED **");
      end else begin
         $display("** dtw_traceback_path_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dtwtb_pkg.sv
hw/rtl/dtwtb_ctrl.sv
hw/rtl/dtwtb_datapath.sv
hw/rtl/dtw_traceback_path_core.sv
bench/dtw_traceback_path_core_tb.sv
